@@ hdl/mergeable_priority_queues_macros.svh @@
// Assertion macros for the mergeable priority queue engine.
// Used by the top level; empty bodies when SYNTHESIS is defined.
`ifndef MERGEABLE_PRIORITY_QUEUES_MACROS_SVH
`define MERGEABLE_PRIORITY_QUEUES_MACROS_SVH
`ifndef SYNTHESIS
`define MPQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define MPQ_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MPQ_ASSERT(label, clk, rst, prop)
`define MPQ_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ hdl/mpq_pkg.sv @@
// Package for the mergeable priority queue engine: sizes, operation codes,
// entry type and controller states. No dependencies.
package mpq_pkg;
  localparam int NumQueues = 16;
  localparam int Capacity = 1024;
  localparam int QW = 4;
  localparam int AW = $clog2(Capacity);
  localparam int CW = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_JOIN = 2'd1,
    OP_POP = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] queue_index;
    logic [3:0] source_index;
    logic signed [31:0] key;
    logic [63:0] name_high;
    logic [63:0] name_mid;
    logic [31:0] name_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_name_high;
    logic [63:0] out_name_mid;
    logic [31:0] out_name_low;
    logic was_empty;
    logic overflowed;
  } out_item_t;

  // One stored entry: valid, owner, key and name.
  typedef struct packed {
    logic valid;
    logic [QW-1:0] owner;
    logic signed [31:0] key;
    logic [159:0] name;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_t;

  function automatic logic better(input entry_t a, input entry_t b);
    if (a.key != b.key) return a.key < b.key;
    return a.name > b.name;
  endfunction
endpackage

@@ hdl/mpq_if.sv @@
// Valid/ready channel interface with a payload type parameter.
// No dependencies; the payload type comes in as a parameter.
interface mpq_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/mpq_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module mpq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0] wdata,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ hdl/mergeable_priority_queues.sv @@
// Mergeable priority queue engine. Entries live in one RAM of Capacity words.
// After reset a clearing pass writes every word before the first transfer is taken.
// Each entry is read and then written back where the operation changes it; a push
// stops at its first free slot, and a pop frees its best entry, if any, and presents
// its result. One item at a time: a new transfer waits for any result to leave.
// Overflow is cleared by reset only. Depends on mpq_pkg, mpq_if, mpq_ram and the macros.
`include "mergeable_priority_queues_macros.svh"
module mergeable_priority_queues
  import mpq_pkg::*;
(
  input logic clk,
  input logic rst,
  mpq_if.sink in_ch,
  mpq_if.source out_ch
);
  state_t state, state_next;
  in_item_t cmd;
  logic [CW-1:0] addr;
  logic [CW-1:0] rd_addr;
  logic rd_pending;
  logic we;
  logic [AW-1:0] ram_addr;
  entry_t wdata, rdata;
  logic found;
  logic [AW-1:0] best_addr;
  entry_t best;
  logic overflow;
  logic out_valid;
  out_item_t out_data;
  logic q_ok, s_ok, match, scan_done, skip;

  mpq_ram #(.Width(EW), .Depth(Capacity)) u_ram (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
  );

  assign q_ok = 32'(cmd.queue_index) < 32'(NumQueues);
  assign s_ok = 32'(cmd.source_index) < 32'(NumQueues);
  assign match = rd_pending && rdata.valid && rdata.owner == cmd.queue_index;
  assign scan_done = addr == CW'(Capacity);
  assign skip = (cmd.op == OP_PUSH && !q_ok) ||
                (cmd.op == OP_JOIN &&
                 (!s_ok || !q_ok || cmd.source_index == cmd.queue_index));
  assign in_ch.ready = state == ST_IDLE && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.payload = out_data;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: if (scan_done) state_next = ST_IDLE;
      ST_IDLE: if (in_ch.valid && in_ch.ready) state_next = ST_SCAN;
      ST_SCAN: begin
        if (cmd.op == OP_PUSH && rd_pending && !rdata.valid) state_next = ST_IDLE;
        else if (scan_done && !rd_pending) begin
          state_next = (cmd.op == OP_POP) ? ST_WRITE : ST_IDLE;
        end
      end
      ST_WRITE: state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM port: init clears; scan reads, then writes back; pop frees its best entry.
  always_comb begin
    we = 1'b0;
    ram_addr = addr[AW-1:0];
    wdata = rdata;
    unique case (state)
      ST_INIT: begin
        we = 1'b1;
        wdata = '0;
      end
      ST_SCAN: begin
        if (rd_pending) begin
          ram_addr = rd_addr[AW-1:0];
          unique case (cmd.op)
            OP_PUSH: if (!rdata.valid) begin
              we = 1'b1;
              wdata = {1'b1, cmd.queue_index, cmd.key,
                       cmd.name_high, cmd.name_mid, cmd.name_low};
            end
            OP_JOIN: if (rdata.valid && rdata.owner == cmd.source_index) begin
              we = 1'b1;
              wdata.owner = cmd.queue_index;
            end
            OP_CLEAR: begin
              we = 1'b1;
              wdata.valid = 1'b0;
            end
            default: we = 1'b0;
          endcase
        end
      end
      ST_WRITE: begin
        ram_addr = best_addr;
        we = found;
        wdata = best;
        wdata.valid = 1'b0;
      end
      default: we = 1'b0;
    endcase
  end

  // Reads and writes alternate, so a slot is written in the cycle after its read.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      addr <= '0;
      rd_pending <= 1'b0;
      overflow <= 1'b0;
      out_valid <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        ST_INIT: begin
          addr <= scan_done ? '0 : addr + 1'b1;
        end
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            cmd <= in_ch.payload;
            addr <= '0;
            rd_pending <= 1'b0;
            found <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (skip) begin
            addr <= CW'(Capacity);
            rd_pending <= 1'b0;
          end else if (!rd_pending && !scan_done) begin
            rd_addr <= addr;
            rd_pending <= 1'b1;
            addr <= addr + 1'b1;
          end else begin
            rd_pending <= 1'b0;
          end
          if (cmd.op == OP_PUSH && scan_done && !rd_pending && q_ok) overflow <= 1'b1;
          if (cmd.op == OP_POP && match && q_ok && (!found || better(rdata, best))) begin
            found <= 1'b1;
            best <= rdata;
            best_addr <= rd_addr[AW-1:0];
          end
        end
        ST_WRITE: begin
          out_valid <= 1'b1;
          out_data.out_name_high <= found ? best.name[159:96] : '0;
          out_data.out_name_mid <= found ? best.name[95:32] : '0;
          out_data.out_name_low <= found ? best.name[31:0] : '0;
          out_data.was_empty <= !found;
          out_data.overflowed <= overflow;
        end
        default: ;
      endcase
    end
  end

  `MPQ_ASSERT(a_out_only_after_pop, clk, rst, $rose(out_valid) |-> $past(state) == ST_WRITE && cmd.op == OP_POP)
  `MPQ_ASSERT(a_no_accept_with_result, clk, rst, out_valid |-> !in_ch.ready)
  `MPQ_ASSERT_NR(a_overflow_sticky, clk, $past(!rst && overflow) |-> overflow)
endmodule

@@ verif/mpq_scoreboard.sv @@
// Scoreboard for the mergeable priority queue engine: keeps its own copy of
// the entry store and predicts every pop result. Depends on mpq_pkg.
package mpq_scoreboard_pkg;
  import mpq_pkg::*;

  class mpq_scoreboard;
    logic signed [31:0] slot_key [Capacity];
    logic [159:0] slot_name [Capacity];
    logic [3:0] slot_owner [Capacity];
    bit slot_used [Capacity];
    bit overflow;
    out_item_t pending_pops [$];
    int errors;
    int pops_checked;
    int empty_pops;
    int dropped_pushes;

    function void reset_store();
      foreach (slot_used[i]) slot_used[i] = 0;
      overflow = 0;
      pending_pops.delete();
    endfunction

    function int live_count();
      int n;
      n = 0;
      foreach (slot_used[i]) if (slot_used[i]) n++;
      return n;
    endfunction

    function int queue_size(input logic [3:0] q);
      int n;
      n = 0;
      foreach (slot_used[i]) if (slot_used[i] && slot_owner[i] == q) n++;
      return n;
    endfunction

    function void note_transfer(input in_item_t it);
      int best;
      bit placed;
      out_item_t r;
      placed = 0;
      best = -1;
      case (op_t'(it.op))
        OP_PUSH: begin
          for (int i = 0; i < Capacity && !placed; i++) begin
            if (!slot_used[i]) begin
              slot_used[i] = 1;
              slot_key[i] = it.key;
              slot_name[i] = {it.name_high, it.name_mid, it.name_low};
              slot_owner[i] = it.queue_index;
              placed = 1;
            end
          end
          if (!placed) begin
            overflow = 1;
            dropped_pushes++;
          end
        end
        OP_JOIN: begin
          if (it.source_index != it.queue_index) begin
            foreach (slot_used[i])
              if (slot_used[i] && slot_owner[i] == it.source_index)
                slot_owner[i] = it.queue_index;
          end
        end
        OP_CLEAR: begin
          foreach (slot_used[i]) slot_used[i] = 0;
        end
        default: begin
          foreach (slot_used[i]) begin
            if (slot_used[i] && slot_owner[i] == it.queue_index) begin
              if (best < 0 || slot_key[i] < slot_key[best] ||
                  (slot_key[i] == slot_key[best] && slot_name[i] > slot_name[best]))
                best = i;
            end
          end
          r = '0;
          if (best >= 0) begin
            {r.out_name_high, r.out_name_mid, r.out_name_low} = slot_name[best];
            slot_used[best] = 0;
          end else begin
            r.was_empty = 1;
            empty_pops++;
          end
          r.overflowed = overflow;
          pending_pops = {pending_pops, r};
        end
      endcase
    endfunction

    function void check_result(input out_item_t got);
      out_item_t exp;
      if (pending_pops.size() == 0) begin
        $error("result arrived with no pop outstanding");
        errors++;
        return;
      end
      exp = pending_pops.pop_front();
      pops_checked++;
      if (got.out_name_high !== exp.out_name_high) begin
        $error("out_name_high expected %h actual %h", exp.out_name_high, got.out_name_high);
        errors++;
      end
      if (got.out_name_mid !== exp.out_name_mid) begin
        $error("out_name_mid expected %h actual %h", exp.out_name_mid, got.out_name_mid);
        errors++;
      end
      if (got.out_name_low !== exp.out_name_low) begin
        $error("out_name_low expected %h actual %h", exp.out_name_low, got.out_name_low);
        errors++;
      end
      if (got.was_empty !== exp.was_empty) begin
        $error("was_empty expected %b actual %b", exp.was_empty, got.was_empty);
        errors++;
      end
      if (got.overflowed !== exp.overflowed) begin
        $error("overflowed expected %b actual %b", exp.overflowed, got.overflowed);
        errors++;
      end
    endfunction
  endclass
endpackage

@@ verif/tb.sv @@
// Top-level testbench for mergeable_priority_queues: directed and random
// push, join, pop and clear traffic with random idling and a long stall.
// Depends on mpq_pkg, mpq_if, mpq_scoreboard_pkg and the RTL.
module tb;
  import mpq_pkg::*;
  import mpq_scoreboard_pkg::*;

  localparam int CycleLimit = 6000000;
  localparam int StallStart = 100000;
  localparam int StallLength = 20000;

  logic clk;
  logic rst;
  longint unsigned cycles;
  bit hold_off;
  bit stim_done;
  int items_sent;
  mpq_scoreboard board;

  mpq_if #(.T(in_item_t)) in_ch (clk);
  mpq_if #(.T(out_item_t)) out_ch (clk);

  mergeable_priority_queues uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) board.note_transfer(in_ch.payload);
    if (!rst && out_ch.valid && out_ch.ready) board.check_result(out_ch.payload);
  end

  // The long hold-off of the receiver is timed in cycles here.
  initial begin
    hold_off = 1'b0;
    repeat (StallStart) @(negedge clk);
    hold_off = 1'b1;
    repeat (StallLength) @(negedge clk);
    hold_off = 1'b0;
  end

  // Receiver stalls on its own pattern; a long hold-off is forced from outside.
  initial begin
    int phase;
    out_ch.ready = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_off) out_ch.ready <= 1'b0;
      else if ((phase / 200) % 3 == 0) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send(input in_item_t it);
    in_ch.payload <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic gap();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(negedge clk);
  endtask

  function automatic in_item_t make_item(input op_t op, input logic [3:0] q,
                                         input logic [3:0] s);
    in_item_t it;
    it.op = op;
    it.queue_index = q;
    it.source_index = s;
    it.key = $urandom_range(0, 7) == 0 ? $urandom() : $signed($urandom_range(0, 6)) - 3;
    it.name_high = {$urandom(), $urandom()};
    it.name_mid = {$urandom(), $urandom()};
    it.name_low = $urandom();
    if ($urandom_range(0, 2) == 0) begin
      it.name_high[31:0] = '0;
      it.name_mid = '0;
      it.name_low = '0;
    end
    return it;
  endfunction

  function automatic in_item_t random_item();
    int r;
    logic [3:0] q;
    r = $urandom_range(0, 99);
    q = $urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    if (r < 45) return make_item(OP_PUSH, q, 4'd0);
    if (r < 55) return make_item(OP_JOIN, q, 4'($urandom_range(0, 4)));
    if (r < 99) return make_item(OP_POP, q, 4'($urandom()));
    return make_item(OP_CLEAR, 4'($urandom()), 4'($urandom()));
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending_pops.size() != 0) @(negedge clk);
    repeat (Capacity + 20) @(negedge clk);
  endtask

  initial begin
    in_item_t it;
    int burst;
    board = new();
    board.reset_store();
    cycles = 0;
    items_sent = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, equal keys, tie on names, self join, empty pop, clear.
    it = make_item(OP_POP, 4'd0, 4'd0);
    send(it);
    it = make_item(OP_PUSH, 4'd15, 4'd0);
    it.key = 32'h8000_0000;
    it.name_high = '1; it.name_mid = '1; it.name_low = '1;
    send(it);
    it.key = 32'h7fff_ffff; it.name_high = '0; it.name_mid = '0; it.name_low = '0;
    send(it);
    it.key = 5; it.name_high = 64'h4142_0000_0000_0000;
    send(it);
    send(it);
    it.name_low = 32'h0000_0001;
    send(it);
    it.name_high = 64'h8000_0000_0000_0000; it.name_low = 0;
    send(it);
    send(make_item(OP_JOIN, 4'd15, 4'd15));
    send(make_item(OP_JOIN, 4'd3, 4'd15));
    for (int i = 0; i < 7; i++) send(make_item(OP_POP, 4'd3, 4'd0));
    send(make_item(OP_PUSH, 4'd7, 4'd0));
    send(make_item(OP_CLEAR, 4'd9, 4'd2));
    send(make_item(OP_POP, 4'd7, 4'd0));
    gap();

    // Random traffic in bursts; the receiver holds off for a long stretch part way.
    while (items_sent < 555) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst; i++) begin
        send(random_item());
      end
      if ($urandom_range(0, 2) != 0) gap();
    end
    drain();

    // A few pops, then a clear and a pop of an emptied queue.
    for (int i = 0; i < 4; i++) send(make_item(OP_POP, 4'($urandom_range(0, 15)), 4'd0));
    send(make_item(OP_CLEAR, 4'd0, 4'd0));
    send(make_item(OP_POP, 4'd1, 4'd0));
    drain();

    $display("sent %0d items, checked %0d pops (%0d empty), %0d pushes dropped",
             items_sent, board.pops_checked, board.empty_pops, board.dropped_pushes);
    if (board.errors == 0 && board.pending_pops.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ mergeable_priority_queues.f @@
+incdir+hdl
hdl/mpq_pkg.sv
hdl/mpq_if.sv
hdl/mpq_ram.sv
hdl/mergeable_priority_queues.sv
verif/mpq_scoreboard.sv
verif/tb.sv
